FILE: hw/rtl/dpd_pkg.sv
// dpd_pkg: constants, register indexes, phase codes and shared types
// for the divergence phase detector
// no dependencies
package dpd_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned ALPHA_W  = 17;
    localparam int unsigned SCORE_W  = 4;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // fixed point one and score ceiling
    localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 4'd10;

    // register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 17'd19661;
    localparam logic [SAMPLE_W-1:0] RATE_THR_RST   = 24'd6554;
    localparam logic [SCORE_W-1:0]  STABLE_RST     = 4'd7;
    localparam logic [SCORE_W-1:0]  PRE_RST        = 4'd4;
    localparam logic [SCORE_W-1:0]  TRANSITION_RST = 4'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION = 3'd4;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_STABLE        = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRE           = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TRANSITIONING = 2'd2;
    localparam logic [PHASE_W-1:0] PH_POST          = 2'd3;

    // score thresholds handed to the score stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] rate_threshold;
        logic [SCORE_W-1:0]  stable_above;
        logic [SCORE_W-1:0]  pre_above;
        logic [SCORE_W-1:0]  transitioning_above;
    } t_thresh;

    // next score state from the score stage
    typedef struct packed {
        logic [SCORE_W-1:0] stability;
        logic [PHASE_W-1:0] phase;
        logic               changed;
    } t_score;

endpackage

FILE: hw/rtl/dpd_score.sv
// dpd_score: stability score update and phase selection for one beat
// depends on dpd_pkg
module dpd_score
    import dpd_pkg::*;
(
    input  t_thresh             i_thresh,
    input  logic [SAMPLE_W-1:0] i_avg,
    input  logic [SCORE_W-1:0]  i_stability,
    input  logic [PHASE_W-1:0]  i_phase,
    output t_score              o_next
);

    logic [SCORE_W-1:0] w_stab;
    logic [PHASE_W-1:0] w_phase;

    // score rises below threshold, falls otherwise, clamped at 0 and max
    always_comb begin
        if (i_avg < i_thresh.rate_threshold) begin
            w_stab = (i_stability < SCORE_MAX) ? i_stability + 4'd1 : i_stability;
        end else begin
            w_stab = (i_stability != 4'd0) ? i_stability - 4'd1 : i_stability;
        end
    end

    // phase from score thresholds, highest first
    always_comb begin
        if (w_stab > i_thresh.stable_above) begin
            w_phase = PH_STABLE;
        end else if (w_stab > i_thresh.pre_above) begin
            w_phase = PH_PRE;
        end else if (w_stab > i_thresh.transitioning_above) begin
            w_phase = PH_TRANSITIONING;
        end else begin
            w_phase = PH_POST;
        end
    end

    assign o_next.stability = w_stab;
    assign o_next.phase     = w_phase;
    assign o_next.changed   = (w_phase != i_phase);

endmodule

FILE: hw/rtl/divergence_phase_detector.sv
// divergence_phase_detector: moving average, stability score and phase tracking
// an accepted input beat passes the input, average and score registers before its result beat reaches the output
// throughput: one beat per cycle while the result side does not stall; the average update is one 17x25 multiply-add
// reset: synchronous active low; average 0, score 10, phase stable, counter 0, defaults loaded
// depends on dpd_pkg and dpd_score
module divergence_phase_detector
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input sample channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_divergence,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PHASE_W-1:0]    o_phase,
    output logic                  o_phase_changed,
    output logic [COUNT_W-1:0]    o_change_total,
    output logic [SCORE_W-1:0]    o_stability_tenths,
    output logic [SAMPLE_W-1:0]   o_average_rate,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [ALPHA_W-1:0]  r_alpha;
    t_thresh             r_thresh;

    // pipeline valids and stage enables
    logic r_v0, r_v1, r_v2;
    logic w_en0, w_en1, w_en2;

    // stage payloads and state
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] r_avg_out;
    logic [SCORE_W-1:0]  r_stab;
    logic [PHASE_W-1:0]  r_phase;
    logic [COUNT_W-1:0]  r_cnt;
    logic                r_changed;

    logic [SAMPLE_W-1:0] n_avg;
    t_score              w_score;

    // configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha                      <= ALPHA_RST;
            r_thresh.rate_threshold      <= RATE_THR_RST;
            r_thresh.stable_above        <= STABLE_RST;
            r_thresh.pre_above           <= PRE_RST;
            r_thresh.transitioning_above <= TRANSITION_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:      r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_RATE_THR:   r_thresh.rate_threshold <= i_cfg_data[SAMPLE_W-1:0];
                CFG_STABLE:     r_thresh.stable_above <= i_cfg_data[SCORE_W-1:0];
                CFG_PRE:        r_thresh.pre_above <= i_cfg_data[SCORE_W-1:0];
                CFG_TRANSITION: r_thresh.transitioning_above <= i_cfg_data[SCORE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-stage flow control: a stage loads when empty or when it moves on
    assign w_en2   = !r_v2 || !i_stall;
    assign w_en1   = !r_v1 || w_en2;
    assign w_en0   = !r_v0 || w_en1;
    assign o_stall = !w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_en0 && i_valid) begin
            r_sample <= i_divergence;
        end
    end

    // moving average: avg + a*(sample - avg), one multiplier
    logic [ALPHA_W-1:0]  w_alpha;
    logic signed [24:0]  w_diff;
    logic signed [42:0]  w_prod;
    logic signed [42:0]  w_mix;

    always_comb begin
        w_alpha = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;
        w_diff  = $signed({1'b0, r_sample}) - $signed({1'b0, r_avg});
        w_prod  = 43'($signed({1'b0, w_alpha}) * w_diff);
        w_mix   = $signed({3'b000, r_avg, 16'h0000}) + w_prod;
        n_avg   = w_mix[39:16];
    end

    // average state doubles as the stage one payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (w_en1 && r_v0) begin
            r_avg <= n_avg;
        end
    end

    // score stage
    dpd_score u_score (
        .i_thresh    (r_thresh),
        .i_avg       (r_avg),
        .i_stability (r_stab),
        .i_phase     (r_phase),
        .o_next      (w_score)
    );

    // score, phase and counter state, which are also the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stab  <= SCORE_MAX;
            r_phase <= PH_STABLE;
            r_cnt   <= '0;
        end else if (w_en2 && r_v1) begin
            r_stab  <= w_score.stability;
            r_phase <= w_score.phase;
            if (w_score.changed) begin
                r_cnt <= r_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_changed <= w_score.changed;
            r_avg_out <= r_avg;
        end
    end

    assign o_valid            = r_v2;
    assign o_phase            = r_phase;
    assign o_phase_changed    = r_changed;
    assign o_change_total     = r_cnt;
    assign o_stability_tenths = r_stab;
    assign o_average_rate     = r_avg_out;

`ifndef SYNTHESIS
    // score never leaves its range
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stab <= SCORE_MAX)
        else $error("stability score out of range");

    // counter advances by exactly the change flag of each new result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en2 && r_v1) |=> (o_change_total ==
            $past(o_change_total) + {31'd0, o_phase_changed}))
        else $error("change counter does not follow change flag");

    // score state holds between results
    a_score_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_en2 && r_v1) |=> $stable(r_stab) && $stable(r_phase) && $stable(r_cnt))
        else $error("score state moved without a beat");

    // an empty output register never backs up the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v2 |-> !o_stall)
        else $error("input stalled while output register empty");
`endif

endmodule

FILE: tb/dpd_checker.sv
// dpd_checker: watches the sample, result and register channels of the
// divergence phase detector, predicts each result beat and compares it
// depends on dpd_pkg
module dpd_checker
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [SAMPLE_W-1:0]   i_divergence,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PHASE_W-1:0]    i_phase,
    input  logic                  i_phase_changed,
    input  logic [COUNT_W-1:0]    i_change_total,
    input  logic [SCORE_W-1:0]    i_stability_tenths,
    input  logic [SAMPLE_W-1:0]   i_average_rate,
    // register write channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status for the stimulus side
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic                changed;
        logic [COUNT_W-1:0]  total;
        logic [SCORE_W-1:0]  score;
        logic [SAMPLE_W-1:0] rate;
    } t_phase_result;

    // register copies
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [SAMPLE_W-1:0] rate_thr;
    logic [SCORE_W-1:0]  stable_lim;
    logic [SCORE_W-1:0]  pre_lim;
    logic [SCORE_W-1:0]  trans_lim;

    // tracker state
    logic [SAMPLE_W-1:0] avg_rate;
    logic [SCORE_W-1:0]  score;
    logic [PHASE_W-1:0]  cur_phase;
    logic [COUNT_W-1:0]  change_count;

    t_phase_result phase_results_q[$];
    t_phase_result want;
    int            fail_total = 0;
    int            pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    task automatic report_fail(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    // advance the moving average, score and phase by one sample
    task automatic track_sample(input logic [SAMPLE_W-1:0] sample);
        logic [ALPHA_W-1:0] weight;
        logic [63:0]        mix;
        logic [PHASE_W-1:0] next_phase;
        t_phase_result      r;
        weight = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
        mix = 64'(weight) * 64'(sample) + 64'(ONE_Q16 - weight) * 64'(avg_rate);
        avg_rate = mix[39:16];
        if (avg_rate < rate_thr) begin
            if (score < SCORE_MAX) score = score + 1'b1;
        end else if (score != '0) begin
            score = score - 1'b1;
        end
        if (score > stable_lim)     next_phase = PH_STABLE;
        else if (score > pre_lim)   next_phase = PH_PRE;
        else if (score > trans_lim) next_phase = PH_TRANSITIONING;
        else                        next_phase = PH_POST;
        r.changed = (next_phase != cur_phase);
        if (r.changed) change_count = change_count + 1'b1;
        cur_phase = next_phase;
        r.phase = cur_phase;
        r.total = change_count;
        r.score = score;
        r.rate  = avg_rate;
        phase_results_q.push_back(r);
    endtask

    // register writes, result compare and prediction on each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha_reg    = ALPHA_RST;
            rate_thr     = RATE_THR_RST;
            stable_lim   = STABLE_RST;
            pre_lim      = PRE_RST;
            trans_lim    = TRANSITION_RST;
            avg_rate     = '0;
            score        = SCORE_MAX;
            cur_phase    = PH_STABLE;
            change_count = '0;
            phase_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ALPHA:      alpha_reg  = i_cfg_data[ALPHA_W-1:0];
                    CFG_RATE_THR:   rate_thr   = i_cfg_data[SAMPLE_W-1:0];
                    CFG_STABLE:     stable_lim = i_cfg_data[SCORE_W-1:0];
                    CFG_PRE:        pre_lim    = i_cfg_data[SCORE_W-1:0];
                    CFG_TRANSITION: trans_lim  = i_cfg_data[SCORE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (phase_results_q.size() == 0) begin
                    report_fail("result beat with nothing expected");
                end else begin
                    want = phase_results_q.pop_front();
                    if (i_phase !== want.phase)
                        report_fail($sformatf("phase got %0d exp %0d", i_phase, want.phase));
                    if (i_phase_changed !== want.changed)
                        report_fail($sformatf("phase_changed got %0d exp %0d",
                                              i_phase_changed, want.changed));
                    if (i_change_total !== want.total)
                        report_fail($sformatf("change_total got %0d exp %0d",
                                              i_change_total, want.total));
                    if (i_stability_tenths !== want.score)
                        report_fail($sformatf("stability got %0d exp %0d",
                                              i_stability_tenths, want.score));
                    if (i_average_rate !== want.rate)
                        report_fail($sformatf("average_rate got %h exp %h",
                                              i_average_rate, want.rate));
                end
            end
            if (i_in_valid && !i_in_stall) track_sample(i_divergence);
        end
        pending_count <= phase_results_q.size();
    end

endmodule

FILE: tb/tb_top.sv
// tb_top: clock, reset and stimulus for the divergence phase detector,
// with random idling on both channels and the final verdict
// depends on dpd_pkg, divergence_phase_detector and dpd_checker
module tb_top
    import dpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_FIRST = CFG_TRANSITION + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LAST  = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_divergence = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [PHASE_W-1:0]    o_phase;
    logic                  o_phase_changed;
    logic [COUNT_W-1:0]    o_change_total;
    logic [SCORE_W-1:0]    o_stability_tenths;
    logic [SAMPLE_W-1:0]   o_average_rate;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                    fail_count;
    int                    pending_results;
    logic                  quiet = 1'b0;
    logic [SAMPLE_W-1:0]   rate_limit = RATE_THR_RST;

    divergence_phase_detector i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_divergence       (i_divergence),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_phase            (o_phase),
        .o_phase_changed    (o_phase_changed),
        .o_change_total     (o_change_total),
        .o_stability_tenths (o_stability_tenths),
        .o_average_rate     (o_average_rate),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    dpd_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_divergence       (i_divergence),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_phase            (o_phase),
        .i_phase_changed    (o_phase_changed),
        .i_change_total     (o_change_total),
        .i_stability_tenths (o_stability_tenths),
        .i_average_rate     (o_average_rate),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending_results)
    );

    // clock and reset
    always #1 i_clk = ~i_clk;

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // cycles to idle before the next beat; none during quiet stretches
    function automatic int draw_wait();
        if (quiet) return 0;
        return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 17);
    endfunction

    // send one sample beat after a random gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_divergence <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait until every result beat has come out
    task automatic pause_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] alpha,
                                 input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] stable_lim,
                                 input logic [CFG_DATA_W-1:0] pre_lim,
                                 input logic [CFG_DATA_W-1:0] trans_lim);
        pause_input();
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_RATE_THR, thr);
        write_reg(CFG_STABLE, stable_lim);
        write_reg(CFG_PRE, pre_lim);
        write_reg(CFG_TRANSITION, trans_lim);
        rate_limit = thr[SAMPLE_W-1:0];
    endtask

    // bursts of low or high samples sweep the score through the phases
    task automatic send_random(input int count);
        int sent;
        int burst;
        int kind;
        logic [SAMPLE_W-1:0] value;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 14);
            kind  = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < burst && sent < count; k++) begin
                if (kind < 4)      value = 24'($urandom_range(0, rate_limit));
                else if (kind < 8) value = 24'($urandom_range(rate_limit, 24'hFFFFFF));
                else if (kind < 9) value = 24'($urandom());
                else               value = ($urandom_range(0, 1) != 0) ? '1 : '0;
                send_sample(value);
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    // result side stall
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // main sequence
    initial begin
        wait (i_rst_n === 1'b1);

        // directed at reset settings: full swing down through every phase
        repeat (3) send_sample('0);
        repeat (11) send_sample('1);
        send_sample(24'h000001);
        send_sample(24'hAAAAAA);
        send_sample(24'h555555);
        repeat (8) send_sample('0);
        send_random(PHASE_ITEMS);

        // alpha exactly one: the average follows the sample
        apply_setting(24'h010000, 24'h000400, 24'd10, 24'd5, 24'd2);
        send_random(PHASE_ITEMS);

        // alpha above one after masking, zero threshold, stable and pre limits above ten
        apply_setting(24'hFFFFFF, 24'h000000, 24'd15, 24'd11, 24'd0);
        send_random(PHASE_ITEMS);

        // alpha zero freezes the average, threshold at maximum
        apply_setting(24'h000000, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
        send_random(PHASE_ITEMS);

        // smallest nonzero alpha and threshold, limits at ten
        apply_setting(24'h000001, 24'h000001, 24'd10, 24'd10, 24'd10);
        send_random(PHASE_ITEMS);

        // writes past the register list must be ignored
        apply_setting(24'h00FFFF, 24'h800000, 24'd9, 24'd5, 24'd2);
        write_reg(CFG_NONE_FIRST, 24'($urandom()));
        write_reg(CFG_NONE_LAST, 24'($urandom()));
        send_random(PHASE_ITEMS);

        // random settings
        apply_setting(24'($urandom_range(0, 131071)), 24'($urandom()),
                      24'($urandom_range(0, 15)), 24'($urandom_range(0, 15)),
                      24'($urandom_range(0, 15)));
        send_random(PHASE_ITEMS);

        // back to reset defaults
        apply_setting(24'(ALPHA_RST), RATE_THR_RST, 24'(STABLE_RST), 24'(PRE_RST),
                      24'(TRANSITION_RST));
        send_random(PHASE_ITEMS);

        pause_input();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_score.sv
hw/rtl/divergence_phase_detector.sv
tb/dpd_checker.sv
tb/tb_top.sv
